// File: rtl/sem_pkg.sv
// sem_pkg: shared types, constants and state encodings of the sobel edge magnitude unit
// no dependencies; used by sem_front, sem_back and the top level
package sem_pkg;

   localparam int DEF_MAX_WIDTH = 2048;
   localparam int IN_Q_DEPTH    = 4;
   localparam int OUT_Q_DEPTH   = 4;

   localparam int CFG_W  = 12;
   localparam int PIX_W  = 8;
   localparam int GRAD_W = 11;
   localparam int SQ_W   = 21;
   localparam int ROOT_W = 16;

   localparam logic [15:0] W_RED   = 16'd19595;
   localparam logic [15:0] W_GREEN = 16'd38470;
   localparam logic [15:0] W_BLUE  = 16'd7471;
   localparam logic [24:0] ROUND_HALF = 25'd32768;
   localparam logic [SQ_W-1:0] SAT_LIMIT = 21'd65280;
   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
   localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef struct packed {
      logic             command;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] edge_res;
      logic             last_in_step;
      logic             frame_end;
   } rsp_type;

   typedef struct packed {
      logic             command;
      logic [PIX_W-1:0] gray;
   } gray_item_type;

   typedef struct packed {
      logic [CFG_W-1:0] frame_width;
      logic [CFG_W-1:0] frame_height;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_GRAD,
      ST_SQUARE,
      ST_ROOT,
      ST_EMIT
   } back_state_type;

endpackage

// File: rtl/sem_queue.sv
// sem_queue: small first-in first-out queue of words
// depends on nothing but its type parameter
module sem_queue #(
   parameter int DEPTH = 4,
   parameter type ITEM_TYPE = logic
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ITEM_TYPE                   push_data,
   input  logic                       pop,
   output ITEM_TYPE                   pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH+1);

   ITEM_TYPE        store_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = store_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

// File: rtl/sem_front.sv
// sem_front: accepts input words and turns each pixel into a gray value
// depends on sem_pkg; feeds the input queue
module sem_front
   import sem_pkg::*;
#(
   parameter int Q_DEPTH = IN_Q_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  req_type                      req_data,
   input  logic                         hold,
   output logic                         full,
   input  logic [$clog2(Q_DEPTH+1)-1:0] q_count,
   output logic                         q_push,
   output gray_item_type                q_data
);
   localparam int CNTW = $clog2(Q_DEPTH+1);

   logic        vld_ff, vld_in;
   logic        cmd_ff, cmd_in;
   logic [23:0] pr_ff, pr_in;
   logic [23:0] pg_ff, pg_in;
   logic [23:0] pb_ff, pb_in;
   logic        accept;
   logic [24:0] sum;

   // one word can be in flight in the product stage, so keep a slot spare
   assign full   = hold || (q_count >= CNTW'(Q_DEPTH-1));
   assign accept = req_push && !full;

   always_comb begin
      vld_in = accept;
      cmd_in = req_data.command;
      pr_in  = 24'(W_RED * 24'(req_data.red));
      pg_in  = 24'(W_GREEN * 24'(req_data.green));
      pb_in  = 24'(W_BLUE * 24'(req_data.blue));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      pr_ff  <= pr_in;
      pg_ff  <= pg_in;
      pb_ff  <= pb_in;
   end

   assign sum = 25'(pr_ff) + 25'(pg_ff) + 25'(pb_ff) + ROUND_HALF;

   assign q_push         = vld_ff;
   assign q_data.command = cmd_ff;
   assign q_data.gray    = sum[23:16];

endmodule

// File: rtl/sem_back.sv
// sem_back: row stores, sobel window, gradient and bit-serial rounded square root
// depends on sem_pkg; drains the input queue and fills the result queue
module sem_back
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int OUT_DEPTH = OUT_Q_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  logic                           in_empty,
   input  gray_item_type                  in_data,
   output logic                           in_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
   output logic                           out_push,
   output rsp_type                        out_data,
   output logic                           clearing
);
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = ((CW > CFG_W) ? CW : CFG_W) + 1;
   localparam int OCW  = $clog2(OUT_DEPTH+1);

   logic [PIX_W-1:0] row_upper_mem [MAX_WIDTH];
   logic [PIX_W-1:0] row_lower_mem [MAX_WIDTH];

   back_state_type          state_ff, state_in;
   logic [CW-1:0]           clr_ff, clr_in;
   logic [CW-1:0]           col_ff, col_in;
   logic [CFG_W-1:0]        row_ff, row_in;
   gray_item_type           item_ff, item_in;
   logic [PIX_W-1:0]        rd_up_ff, rd_lo_ff;
   logic [PIX_W-1:0]        win_ff [9];
   logic [PIX_W-1:0]        win_in [9];
   logic                    job_a_ff, job_a_in;
   logic                    job_b_ff, job_b_in;
   logic                    drain_ff, drain_in;
   logic                    sel_b_ff, sel_b_in;
   logic signed [GRAD_W-1:0] gx_ff, gx_in;
   logic signed [GRAD_W-1:0] gy_ff, gy_in;
   logic [ROOT_W-1:0]       res_ff, res_in;
   logic [ROOT_W-1:0]       rem_ff, rem_in;
   logic [ROOT_W-2:0]       bit_ff, bit_in;
   logic [2:0]              step_ff, step_in;

   logic                    rd_en;
   logic                    mem_we;
   logic [CW-1:0]           mem_addr;
   logic [PIX_W-1:0]        wr_up, wr_lo;

   logic [CMPW-1:0]         w_eff, w_raw;
   logic [CFG_W-1:0]        h_eff;
   logic                    drain_row, last_col;
   logic [PIX_W-1:0]        v, top, mid;
   logic [PIX_W-1:0]        l0, l1, l2, c0, c2, r0, r1, r2;
   logic signed [GRAD_W+1:0] gx_full, gy_full;
   logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
   logic [SQ_W-1:0]         sq;
   logic [ROOT_W:0]         trial;
   logic [ROOT_W:0]         rounded;

   // effective frame size: zero acts as one, width capped at the store depth
   always_comb begin
      w_raw = (cfg.frame_width == '0) ? CMPW'(1) : CMPW'(cfg.frame_width);
      w_eff = (w_raw > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : w_raw;
      h_eff = (cfg.frame_height == '0) ? CFG_W'(1) : cfg.frame_height;
   end

   assign drain_row = (row_ff >= h_eff);
   assign last_col  = (CMPW'(col_ff) >= (w_eff - 1'b1));
   assign v   = ((item_ff.command == CMD_PIXEL) && !drain_row) ? item_ff.gray : '0;
   assign top = (row_ff <= CFG_W'(1)) ? '0 : rd_up_ff;
   assign mid = rd_lo_ff;

   // second result of a row end repeats the right column
   always_comb begin
      if (sel_b_ff) begin
         l0 = win_ff[3]; l1 = win_ff[4]; l2 = win_ff[5];
         c0 = win_ff[6]; c2 = win_ff[8];
      end else begin
         l0 = win_ff[0]; l1 = win_ff[1]; l2 = win_ff[2];
         c0 = win_ff[3]; c2 = win_ff[5];
      end
      r0 = win_ff[6]; r1 = win_ff[7]; r2 = win_ff[8];
      gx_full = ($signed({5'b0, r0}) + ($signed({5'b0, r1}) <<< 1) + $signed({5'b0, r2}))
              - ($signed({5'b0, l0}) + ($signed({5'b0, l1}) <<< 1) + $signed({5'b0, l2}));
      gy_full = ($signed({5'b0, l2}) + ($signed({5'b0, c2}) <<< 1) + $signed({5'b0, r2}))
              - ($signed({5'b0, l0}) + ($signed({5'b0, c0}) <<< 1) + $signed({5'b0, r0}));
   end

   assign gx_sq   = gx_ff * gx_ff;
   assign gy_sq   = gy_ff * gy_ff;
   assign sq      = SQ_W'(gx_sq) + SQ_W'(gy_sq);
   assign trial   = {1'b0, res_ff} + (ROOT_W+1)'(bit_ff);
   assign rounded = (rem_ff > res_ff) ? ({1'b0, res_ff} + 1'b1) : {1'b0, res_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CW'(MAX_WIDTH-1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!in_empty && (out_count <= OCW'(OUT_DEPTH-2))) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if ((row_ff != '0) && ((col_ff != '0) || last_col)) begin
               state_in = ST_GRAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_GRAD:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = (sq > SAT_LIMIT) ? ST_EMIT : ST_ROOT;
         ST_ROOT: begin
            if (step_ff == 3'd7) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            state_in = (!sel_b_ff && job_b_ff) ? ST_GRAD : ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      clr_in   = clr_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      item_in  = item_ff;
      win_in   = win_ff;
      job_a_in = job_a_ff;
      job_b_in = job_b_ff;
      drain_in = drain_ff;
      sel_b_in = sel_b_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      res_in   = res_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      step_in  = step_ff;
      in_pop   = 1'b0;
      rd_en    = 1'b0;
      mem_we   = 1'b0;
      mem_addr = col_ff;
      wr_up    = mid;
      wr_lo    = v;
      out_push = 1'b0;
      out_data.edge_res     = (rounded > (ROOT_W+1)'(PIX_MAX)) ? PIX_MAX
                                                               : rounded[PIX_W-1:0];
      out_data.last_in_step = sel_b_ff || !job_b_ff;
      out_data.frame_end    = sel_b_ff && drain_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            wr_up    = '0;
            wr_lo    = '0;
            clr_in   = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (!in_empty && (out_count <= OCW'(OUT_DEPTH-2))) begin
               in_pop  = 1'b1;
               rd_en   = 1'b1;
               item_in = in_data;
            end
         end
         ST_UPDATE: begin
            mem_we = 1'b1;
            if (col_ff == '0) begin
               for (int k = 0; k < 3; k++) begin
                  win_in[k*3+0] = top;
                  win_in[k*3+1] = mid;
                  win_in[k*3+2] = v;
               end
            end else begin
               for (int k = 0; k < 6; k++) begin
                  win_in[k] = win_ff[k+3];
               end
               win_in[6] = top;
               win_in[7] = mid;
               win_in[8] = v;
            end
            job_a_in = (row_ff != '0) && (col_ff != '0);
            job_b_in = (row_ff != '0) && last_col;
            drain_in = drain_row;
            sel_b_in = (col_ff == '0);
            if (last_col) begin
               col_in = '0;
               row_in = drain_row ? '0 : row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_GRAD: begin
            gx_in = GRAD_W'(gx_full);
            gy_in = GRAD_W'(gy_full);
         end
         ST_SQUARE: begin
            if (sq > SAT_LIMIT) begin
               res_in = ROOT_W'(PIX_MAX);
               rem_in = '0;
            end else begin
               res_in = '0;
               rem_in = sq[ROOT_W-1:0];
            end
            bit_in  = (ROOT_W-1)'(1) << (ROOT_W-2);
            step_in = '0;
         end
         ST_ROOT: begin
            // one result bit per cycle, remainder kept for rounding
            if ({1'b0, rem_ff} >= trial) begin
               rem_in = rem_ff - trial[ROOT_W-1:0];
               res_in = (res_ff >> 1) + ROOT_W'(bit_ff);
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 1'b1;
         end
         ST_EMIT: begin
            out_push = 1'b1;
            sel_b_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         job_a_ff <= 1'b0;
         job_b_ff <= 1'b0;
         sel_b_ff <= 1'b0;
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         job_a_ff <= job_a_in;
         job_b_ff <= job_b_in;
         sel_b_ff <= sel_b_in;
         win_ff   <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      drain_ff <= drain_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      res_ff   <= res_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
      step_ff  <= step_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_upper_mem[mem_addr] <= wr_up;
         row_lower_mem[mem_addr] <= wr_lo;
      end
      if (rd_en) begin
         rd_up_ff <= row_upper_mem[col_ff];
         rd_lo_ff <= row_lower_mem[col_ff];
      end
   end

   assign clearing = (state_ff == ST_CLEAR);

endmodule

// File: rtl/sobel_edge_magnitude_unit.sv
// Streaming 3x3 sobel edge magnitude of an rgb raster. After reset the row stores are
// swept to zero, during which req_full stays high. Each word then passes the IDLE and
// UPDATE states of the back end, and each result it causes passes GRAD, SQUARE, the
// 8-step bit-serial square root and EMIT, the root being skipped when the magnitude
// saturates. The gray conversion runs ahead through a short queue. Send
// frame_height rows of pixels, then one row of frame_width drain words.
// sobel_edge_magnitude_unit: top level with csr registers, queues and assertions
// depends on sem_pkg, sem_queue, sem_front, sem_back
module sobel_edge_magnitude_unit
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int IQW = $clog2(IN_Q_DEPTH+1);
   localparam int OQW = $clog2(OUT_Q_DEPTH+1);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   cfg_type          cfg;
   logic             csr_wr;

   logic             iq_push, iq_pop, iq_empty;
   gray_item_type    iq_push_data, iq_pop_data;
   logic [IQW-1:0]   iq_count;
   logic             oq_push;
   rsp_type          oq_push_data;
   logic [OQW-1:0]   oq_count;
   logic             clearing;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_FRAME_WIDTH:  width_in  = csr_pwdata[CFG_W-1:0];
            REG_FRAME_HEIGHT: height_in = csr_pwdata[CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_FRAME_WIDTH;
         height_ff <= RST_FRAME_HEIGHT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_FRAME_WIDTH:  csr_prdata = 32'(width_ff);
         REG_FRAME_HEIGHT: csr_prdata = 32'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.frame_width  = width_ff;
   assign cfg.frame_height = height_ff;

   sem_front #(
      .Q_DEPTH (IN_Q_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .hold     (clearing),
      .full     (req_full),
      .q_count  (iq_count),
      .q_push   (iq_push),
      .q_data   (iq_push_data)
   );

   sem_queue #(
      .DEPTH     (IN_Q_DEPTH),
      .ITEM_TYPE (gray_item_type)
   ) u_in_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (iq_push),
      .push_data (iq_push_data),
      .pop       (iq_pop),
      .pop_data  (iq_pop_data),
      .empty     (iq_empty),
      .count     (iq_count)
   );

   sem_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .OUT_DEPTH (OUT_Q_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_empty  (iq_empty),
      .in_data   (iq_pop_data),
      .in_pop    (iq_pop),
      .out_count (oq_count),
      .out_push  (oq_push),
      .out_data  (oq_push_data),
      .clearing  (clearing)
   );

   sem_queue #(
      .DEPTH     (OUT_Q_DEPTH),
      .ITEM_TYPE (rsp_type)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (oq_push),
      .push_data (oq_push_data),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty),
      .count     (oq_count)
   );

`ifndef NO_ASSERTIONS
   a_in_queue_room: assert property (@(posedge clock) disable iff (reset)
      iq_push |-> (iq_count < IQW'(IN_Q_DEPTH)))
      else $error("input queue overflow");

   a_out_queue_room: assert property (@(posedge clock) disable iff (reset)
      oq_push |-> (oq_count < OQW'(OUT_Q_DEPTH)))
      else $error("result queue overflow");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_full)
      else $error("word accepted during row store clearing");

   a_frame_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.frame_end) |-> rsp_data.last_in_step)
      else $error("frame end word not last of its step");
`endif

endmodule
